FILE: hdl/vss_pkg.sv
// shared types and constants for the speech segment smoother
package vss_pkg;

    localparam int FRAME_BITS_DEFAULT = 24;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int IDX_W = 24;
    localparam int LEN_W = 8;
    localparam logic [LEN_W-1:0] MIN_LEN_RESET = 8'd10;

    typedef struct packed {
        logic [IDX_W-1:0] seg_start;
        logic [IDX_W-1:0] seg_end;
    } seg_t;

    // up to two segments caused by one input word, slot0 goes out first
    typedef struct packed {
        logic two;
        seg_t slot1;
        seg_t slot0;
    } seg_pair_t;

endpackage

FILE: hdl/vss_front.sv
// front end: frame counting, run detection, padding, merging and flush
module vss_front #(
    parameter int FRAME_BITS = vss_pkg::FRAME_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic                     speech_flag,
    input  logic                     end_of_stream,
    input  logic [vss_pkg::LEN_W-1:0] min_len,
    output logic                     push,
    output vss_pkg::seg_pair_t       push_data
);

    localparam int F = FRAME_BITS;

    logic [F-1:0] frame_count_reg, frame_count_next;
    logic         prev_speech_reg, prev_speech_next;
    logic [F-1:0] run_begin_reg, run_begin_next;
    logic         pend_valid_reg, pend_valid_next;
    logic [F-1:0] pend_start_reg, pend_start_next;
    logic [F-1:0] pend_end_reg, pend_end_next;

    logic [F:0]   ml_ext;
    logic [F:0]   fmax_ext;
    logic [F-1:0] idx_inc;
    logic         rise;
    logic         fall;
    logic         close_en;
    logic [F-1:0] close_end;
    logic [F-1:0] rb_eff;
    logic [F:0]   run_len;
    logic         keep;
    logic [F-1:0] new_start;
    logic [F:0]   end_sum;
    logic [F-1:0] new_end;
    logic [F:0]   merge_lim;
    logic         merge;
    logic         emit_a;
    logic         emit_b;
    logic [F-1:0] mid_start;
    logic [F-1:0] mid_end;
    logic         mid_valid;

    logic [F+vss_pkg::IDX_W-1:0] w_a_start, w_a_end, w_b_start, w_b_end;

    assign ml_ext   = {{(F-7){1'b0}}, min_len};
    assign fmax_ext = {1'b0, {F{1'b1}}};

    always_comb
    begin
        idx_inc   = (frame_count_reg == {F{1'b1}}) ? frame_count_reg
                                                   : frame_count_reg + 1'b1;
        rise      = speech_flag & ~prev_speech_reg;
        fall      = ~speech_flag & prev_speech_reg;
        close_en  = fall | (end_of_stream & speech_flag);
        close_end = fall ? frame_count_reg : idx_inc;
        rb_eff    = rise ? frame_count_reg : run_begin_reg;

        run_len   = {1'b0, close_end} - {1'b0, rb_eff};
        keep      = close_en & (run_len >= ml_ext);
        new_start = ({1'b0, rb_eff} > ml_ext) ? F'({1'b0, rb_eff} - ml_ext) : '0;
        end_sum   = {1'b0, close_end} + ml_ext;
        new_end   = (end_sum > fmax_ext) ? {F{1'b1}} : end_sum[F-1:0];
        merge_lim = {1'b0, pend_end_reg} + ml_ext;
        merge     = pend_valid_reg & ({1'b0, new_start} <= merge_lim);

        emit_a    = keep & ~merge & pend_valid_reg;
        mid_valid = pend_valid_reg | keep;
        mid_start = (keep & ~merge) ? new_start : pend_start_reg;
        mid_end   = keep ? new_end : pend_end_reg;
        emit_b    = end_of_stream & mid_valid;

        if (end_of_stream)
        begin
            frame_count_next = '0;
            prev_speech_next = 1'b0;
            run_begin_next   = '0;
            pend_valid_next  = 1'b0;
            pend_start_next  = '0;
            pend_end_next    = '0;
        end
        else
        begin
            frame_count_next = idx_inc;
            prev_speech_next = speech_flag;
            run_begin_next   = rb_eff;
            pend_valid_next  = mid_valid;
            pend_start_next  = mid_start;
            pend_end_next    = mid_end;
        end
    end

    // indices go out masked to the output width
    assign w_a_start = {{vss_pkg::IDX_W{1'b0}}, pend_start_reg};
    assign w_a_end   = {{vss_pkg::IDX_W{1'b0}}, pend_end_reg};
    assign w_b_start = {{vss_pkg::IDX_W{1'b0}}, mid_start};
    assign w_b_end   = {{vss_pkg::IDX_W{1'b0}}, mid_end};

    always_comb
    begin
        push_data.two = emit_a & emit_b;
        push_data.slot1.seg_start = w_b_start[vss_pkg::IDX_W-1:0];
        push_data.slot1.seg_end   = w_b_end[vss_pkg::IDX_W-1:0];
        if (emit_a)
        begin
            push_data.slot0.seg_start = w_a_start[vss_pkg::IDX_W-1:0];
            push_data.slot0.seg_end   = w_a_end[vss_pkg::IDX_W-1:0];
        end
        else
        begin
            push_data.slot0.seg_start = w_b_start[vss_pkg::IDX_W-1:0];
            push_data.slot0.seg_end   = w_b_end[vss_pkg::IDX_W-1:0];
        end
    end

    assign push = accept & (emit_a | emit_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            prev_speech_reg <= 1'b0;
            run_begin_reg   <= '0;
            pend_valid_reg  <= 1'b0;
            pend_start_reg  <= '0;
            pend_end_reg    <= '0;
        end
        else if (accept)
        begin
            frame_count_reg <= frame_count_next;
            prev_speech_reg <= prev_speech_next;
            run_begin_reg   <= run_begin_next;
            pend_valid_reg  <= pend_valid_next;
            pend_start_reg  <= pend_start_next;
            pend_end_reg    <= pend_end_next;
        end
    end

endmodule

FILE: hdl/vss_queue.sv
// small fifo of segment records between front and back
module vss_queue #(
    parameter int DEPTH = vss_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  vss_pkg::seg_pair_t push_data,
    input  logic               pop,
    output vss_pkg::seg_pair_t pop_data,
    output logic               full,
    output logic               empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    vss_pkg::seg_pair_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push & ~full;
    assign do_pop   = pop & ~empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/vss_back.sv
// back end: splits segment records into output words behind an output register
module vss_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  vss_pkg::seg_pair_t          q_data,
    output logic                        q_pop,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [2*vss_pkg::IDX_W-1:0] m_axis_tdata,
    output logic                        m_axis_tlast
);

    logic          out_valid_reg, out_valid_next;
    vss_pkg::seg_t out_seg_reg, out_seg_next;
    logic          out_last_reg, out_last_next;
    logic          hold_valid_reg, hold_valid_next;
    vss_pkg::seg_t hold_seg_reg, hold_seg_next;
    logic          free;

    assign free  = ~out_valid_reg | m_axis_tready;
    assign q_pop = free & ~hold_valid_reg & ~q_empty;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_seg_next    = out_seg_reg;
        out_last_next   = out_last_reg;
        hold_valid_next = hold_valid_reg;
        hold_seg_next   = hold_seg_reg;
        if (free)
        begin
            priority if (hold_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_seg_next    = hold_seg_reg;
                out_last_next   = 1'b1;
                hold_valid_next = 1'b0;
            end
            else if (!q_empty)
            begin
                out_valid_next  = 1'b1;
                out_seg_next    = q_data.slot0;
                out_last_next   = ~q_data.two;
                hold_valid_next = q_data.two;
                hold_seg_next   = q_data.slot1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_seg_reg  <= out_seg_next;
        out_last_reg <= out_last_next;
        hold_seg_reg <= hold_seg_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_seg_reg.seg_end, out_seg_reg.seg_start};
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: hdl/vad_segment_smoother.sv
// top level of the speech segment smoother
// One frame decision is taken per clock cycle: the front end updates the
// registered run and pending-segment state and writes any finished
// segments into a four-entry queue, and the back end drains that queue
// through an output register. A frame that yields one segment produces one
// output word; the end-of-stream frame can yield two, which the back end
// sends one after the other, so input is only held off when the queue
// fills behind a stalled output. min_len must be written while idle.
module vad_segment_smoother #(
    parameter int FRAME_BITS  = vss_pkg::FRAME_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = vss_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [vss_pkg::LEN_W-1:0]   cfg_wdata,     // min_len
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // speech_flag
    input  logic                        s_axis_tlast,  // end_of_stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [2*vss_pkg::IDX_W-1:0] m_axis_tdata,  // {seg_end, seg_start}
    output logic                        m_axis_tlast   // last_of_run
);

    logic [vss_pkg::LEN_W-1:0] min_len_reg;
    logic                      accept;
    logic                      push;
    vss_pkg::seg_pair_t        push_data;
    logic                      pop;
    vss_pkg::seg_pair_t        pop_data;
    logic                      full;
    logic                      empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= vss_pkg::MIN_LEN_RESET;
        end
        else if (cfg_we)
        begin
            min_len_reg <= cfg_wdata;
        end
    end

    assign s_axis_tready = ~full;
    assign accept        = s_axis_tvalid & ~full;

    vss_front #(
        .FRAME_BITS (FRAME_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .speech_flag   (s_axis_tdata[0]),
        .end_of_stream (s_axis_tlast),
        .min_len       (min_len_reg),
        .push          (push),
        .push_data     (push_data)
    );

    vss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    vss_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (empty),
        .q_data        (pop_data),
        .q_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
